@@ design/fdsse_pkg.sv @@
// Shared types, constants and the segment decode for the seven-segment encoder.
// No dependencies; every other file in the block imports this package.
package fdsse_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int FRAC_BITS   = 10;
  localparam int VALUE_W     = 24;
  localparam int SHOWN_W     = 14;
  localparam int MAX_SHOWN   = 9999;
  localparam int IDX_W       = $clog2(DIGIT_COUNT);
  localparam int CNT_W       = $clog2(DIGIT_COUNT + 1);
  localparam int MUL_W       = 20;
  localparam int FACT_W      = 10;
  localparam int PROD_W      = MUL_W + FACT_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // largest fixed-point value still scaled: integer part of three digits
  localparam logic [VALUE_W-1:0] FIX_LIMIT = VALUE_W'(999 << FRAC_BITS);

  // reciprocal of ten for 16-bit operands: x / 10 == (x * RECIP10) >> RECIP_SH
  localparam int RECIP10  = 52429;
  localparam int RECIP_SH = 19;
  localparam int RPROD_W  = 32;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [DIGIT_COUNT-1:0] digit_select;
    logic [7:0]             segments;
    logic                   last;
    logic                   overflow;
  } out_t;

  typedef struct packed {
    logic [SHOWN_W-1:0] shown;
    logic [IDX_W-1:0]   dot;
    logic [CNT_W-1:0]   count;
    logic               ovf;
  } job_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

endpackage

@@ design/four_digit_seven_segment_encoder_unit.sv @@
// Four-digit seven-segment encoder: one request in, one result per digit out,
// least significant digit first. Depends on fdsse_pkg and the fdsse_* modules.
//
// Results leave at one per cycle while res_stall is low. Fixed mode always
// sends four digits; integer mode sends one to four digits (up to the highest
// nonzero one). This pace is set by the digit sequencer in the back end, which
// divides by ten once per cycle. The front end scales and saturates a request
// in one registered stage and hands it through a two-entry queue, so new
// requests are taken while the sequencer is still sending digits and while a
// result waits on res_stall. The first digit passes the front-end register,
// the queue and the sequencer's job register on its way to the result register.
module four_digit_seven_segment_encoder_unit import fdsse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  in_t  req_data,
  input  logic req_valid,
  output logic req_stall,
  output out_t res_data,
  output logic res_valid,
  input  logic res_stall
);

  job_t fe_job;
  logic fe_valid;
  logic fe_stall;
  job_t q_job;
  logic q_valid;
  logic q_stall;

  fdsse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .job       (fe_job),
    .job_valid (fe_valid),
    .job_stall (fe_stall)
  );

  fdsse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (fe_job),
    .wr_valid (fe_valid),
    .wr_stall (fe_stall),
    .rd_data  (q_job),
    .rd_valid (q_valid),
    .rd_stall (q_stall)
  );

  fdsse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_valid (q_valid),
    .job_stall (q_stall),
    .res       (res_data),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule

@@ design/fdsse_front.sv @@
// Front end: takes a request, saturates or scales it and works out digit count
// and decimal point position. Depends on fdsse_pkg.
module fdsse_front import fdsse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  in_t  req,
  input  logic req_valid,
  output logic req_stall,
  output job_t job,
  output logic job_valid,
  input  logic job_stall
);

  logic               valid;
  logic               fixed;
  logic               use_prod;
  logic               ovf;
  logic [IDX_W-1:0]   dot;
  logic [PROD_W-1:0]  product;
  logic [SHOWN_W-1:0] base;

  logic [SHOWN_W-1:0] ip;
  logic               int_sat;
  logic               ip_sat;
  logic               big;
  logic [IDX_W-1:0]   dot_c;
  logic [FACT_W-1:0]  factor_c;
  logic [PROD_W-1:0]  product_c;
  logic [SHOWN_W-1:0] base_c;
  logic               load;

  logic [PROD_W-FRAC_BITS-1:0] scaled;
  logic [SHOWN_W-1:0]          shown_c;
  logic [CNT_W-1:0]            count_c;

  assign req_stall = valid && job_stall;
  assign load      = req_valid && !req_stall;
  assign job_valid = valid;

  always_comb begin
    ip      = req.value[FRAC_BITS +: SHOWN_W];
    int_sat = req.value > VALUE_W'(MAX_SHOWN);
    ip_sat  = ip > SHOWN_W'(MAX_SHOWN);
    big     = req.value > FIX_LIMIT;
    if (ip >= SHOWN_W'(100)) begin
      dot_c = IDX_W'(1);
    end else if (ip >= SHOWN_W'(10)) begin
      dot_c = IDX_W'(2);
    end else begin
      dot_c = IDX_W'(3);
    end
    case (dot_c)
      IDX_W'(1): factor_c = FACT_W'(10);
      IDX_W'(2): factor_c = FACT_W'(100);
      default:   factor_c = FACT_W'(1000);
    endcase
    product_c = PROD_W'(req.value[MUL_W-1:0]) * PROD_W'(factor_c);
    if (!req.mode) begin
      base_c = int_sat ? SHOWN_W'(MAX_SHOWN) : req.value[SHOWN_W-1:0];
    end else begin
      base_c = ip_sat ? SHOWN_W'(MAX_SHOWN) : ip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!req_stall) begin
      valid <= req_valid;
    end
    if (load) begin
      fixed    <= req.mode;
      use_prod <= req.mode && !big;
      ovf      <= req.mode ? (big && ip_sat) : int_sat;
      dot      <= (req.mode && !big) ? dot_c : '0;
      product  <= product_c;
      base     <= base_c;
    end
  end

  always_comb begin
    scaled = product[PROD_W-1:FRAC_BITS];
    if (use_prod) begin
      shown_c = (scaled > (PROD_W-FRAC_BITS)'(MAX_SHOWN)) ? SHOWN_W'(MAX_SHOWN)
                                                          : scaled[SHOWN_W-1:0];
    end else begin
      shown_c = base;
    end
    if (fixed || base >= SHOWN_W'(1000)) begin
      count_c = CNT_W'(DIGIT_COUNT);
    end else if (base >= SHOWN_W'(100)) begin
      count_c = CNT_W'(3);
    end else if (base >= SHOWN_W'(10)) begin
      count_c = CNT_W'(2);
    end else begin
      count_c = CNT_W'(1);
    end
    job.shown = shown_c;
    job.dot   = dot;
    job.count = count_c;
    job.ovf   = ovf;
  end

endmodule

@@ design/fdsse_queue.sv @@
// Short job queue between front end and digit sequencer.
// Depends on fdsse_pkg.
module fdsse_queue import fdsse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t wr_data,
  input  logic wr_valid,
  output logic wr_stall,
  output job_t rd_data,
  output logic rd_valid,
  input  logic rd_stall
);

  job_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               push;
  logic               pop;

  assign wr_stall = fill == QFILL_W'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QFILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QFILL_W'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ design/fdsse_back.sv @@
// Digit sequencer: peels one decimal digit a cycle off a queued job, unless
// res_stall holds it, and drives the registered result. Depends on fdsse_pkg.
module fdsse_back import fdsse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t job,
  input  logic job_valid,
  output logic job_stall,
  output out_t res,
  output logic res_valid,
  input  logic res_stall
);

  logic               busy;
  job_t               cur;
  logic [IDX_W-1:0]   k;

  logic               can_emit;
  logic               emit;
  logic               is_last;
  logic               take;
  logic [RPROD_W-1:0] rprod;
  logic [SHOWN_W-1:0] quot;
  logic [SHOWN_W-1:0] rem;
  logic [7:0]         seg;

  assign can_emit  = !res_valid || !res_stall;
  assign emit      = busy && can_emit;
  assign is_last   = (CNT_W'(k) + CNT_W'(1)) == cur.count;
  assign job_stall = busy && !(can_emit && is_last);
  assign take      = job_valid && !job_stall;

  always_comb begin
    rprod = RPROD_W'(cur.shown) * RPROD_W'(RECIP10);
    quot  = SHOWN_W'(rprod >> RECIP_SH);
    rem   = cur.shown - (quot << 3) - (quot << 1);
    seg   = seg_of(rem[3:0]);
    if (cur.dot != '0 && k == cur.dot) begin
      seg[7] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
    end
    if (emit) begin
      res.digit_select <= DIGIT_COUNT'(1) << k;
      res.segments     <= seg;
      res.last         <= is_last;
      res.overflow     <= cur.ovf;
    end
    if (take) begin
      cur <= job;
      k   <= '0;
    end else if (emit) begin
      cur.shown <= quot;
      k         <= k + IDX_W'(1);
    end
  end

endmodule
